// ===== design/llws_pkg.sv =====
package llws_pkg;

  localparam int MAX_CELLS = 256;
  localparam int VW = 24;
  localparam int FW = 17;
  localparam int PW = VW + FW + 1;
  localparam int SW = VW + 3;

  typedef enum logic [1:0] {
    REG_STEPS = 2'd0,
    REG_ATTEN = 2'd1,
    REG_REFL  = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_HEAD_RD,
    ST_HEAD_WR,
    ST_CELL_RD,
    ST_CELL_MUL,
    ST_CELL_WR,
    ST_SELF_MUL,
    ST_SELF_WR,
    ST_FIN_RD,
    ST_FIN_OUT
  } state_t;

  // voltage times unsigned q1.16 factor
  function automatic logic signed [PW-1:0] qmul(logic signed [VW-1:0] v, logic [FW-1:0] f);
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
    a = PW'(v);
    b = PW'($signed({1'b0, f}));
    return a * b;
  endfunction

  // round to nearest, ties up
  function automatic logic signed [PW-17:0] qround(logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + PW'(32768);
    return t[PW-1:16];
  endfunction

  function automatic logic signed [VW-1:0] sat(logic signed [SW-1:0] x);
    logic signed [VW-1:0] r;
    if (x > SW'(8388607)) begin
      r = 24'sh7fffff;
    end else if (x < -SW'(8388608)) begin
      r = 24'sh800000;
    end else begin
      r = x[VW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/llws_ram.sv =====
module llws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== design/lossy_line_wave_step.sv =====
// channel | dir | contents
// s_*     | in  | tdata: u_begin, u_end; tuser: cmd (0 step, 1 fill)
// m_*     | out | tdata: v_begin, v_end
// cfg_*   | in  | register index and write data
//
// a step is limited by the read-multiply-write loop over both wave rams, with
// an extra multiply and write for the middle cell when N is even and nonzero
// a fill writes every ram row, one ram row per cycle
// after reset both rams are cleared with s_tready low
// a waiting result is held in the output register while the next item runs
module lossy_line_wave_step #(
  parameter int MAX_CELLS = llws_pkg::MAX_CELLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // u_begin, u_end
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // v_begin, v_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = (AW > 8) ? AW : 8;
  localparam int VW = llws_pkg::VW;
  localparam int PW = llws_pkg::PW;
  localparam int SW = llws_pkg::SW;
  localparam logic [AW-1:0] LAST = AW'(MAX_CELLS - 1);

  llws_pkg::state_t state, state_next;

  logic [7:0]            steps;
  logic [16:0]           atten;
  logic [16:0]           refl;
  logic signed [VW-1:0]  ub, ue;
  logic                  report;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         n, mirror;
  logic signed [VW-1:0]  fold, bold, fself;
  logic signed [PW-1:0]  prod_fa, prod_fr, prod_ba, prod_br;
  logic signed [VW-1:0]  v_begin, v_end;

  logic                  f_we, b_we;
  logic [AW-1:0]         f_waddr, b_waddr, raddr0, raddr1;
  logic signed [VW-1:0]  f_wdata, b_wdata;
  logic [VW-1:0]         f_rd0, f_rd1, b_rd0, b_rd1;
  logic signed [VW-1:0]  f_head, b_head, f_new, b_new;
  logic                  self_cell, accept, out_free;

  assign n = (CW'(steps) > CW'(LAST)) ? LAST : AW'(steps);
  assign mirror = n - idx;
  assign self_cell = (mirror == idx);
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == llws_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata = {v_end, v_begin};

  assign f_head = llws_pkg::sat(SW'(ub) - SW'($signed(b_rd1)));
  assign b_head = llws_pkg::sat(SW'(ue) - SW'((n == '0) ? f_head : $signed(f_rd1)));
  assign f_new = llws_pkg::sat(SW'(llws_pkg::qround(prod_fa)) +
                               SW'(llws_pkg::qround(prod_fr)));
  assign b_new = llws_pkg::sat(SW'(llws_pkg::qround(prod_ba)) +
                               SW'(llws_pkg::qround(prod_br)));

  always_comb begin
    raddr0 = n;
    raddr1 = n;
    if (state == llws_pkg::ST_HEAD_RD) begin
      raddr0 = '0;
    end else if (state == llws_pkg::ST_CELL_RD) begin
      raddr0 = idx;
      raddr1 = mirror;
    end
  end

  always_comb begin
    f_we = 1'b0;
    b_we = 1'b0;
    f_waddr = idx;
    b_waddr = idx;
    f_wdata = f_new;
    b_wdata = b_new;
    unique case (state)
      llws_pkg::ST_FILL: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wdata = ub;
        b_wdata = ub;
      end
      llws_pkg::ST_HEAD_WR: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_waddr = '0;
        b_waddr = '0;
        f_wdata = f_head;
        b_wdata = b_head;
      end
      llws_pkg::ST_CELL_WR: begin
        f_we = 1'b1;
        b_we = !self_cell;
      end
      llws_pkg::ST_SELF_WR: begin
        b_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  llws_ram #(.WIDTH(VW), .DEPTH(MAX_CELLS)) u_fwd (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr0(raddr0), .raddr1(raddr1), .rdata0(f_rd0), .rdata1(f_rd1)
  );

  llws_ram #(.WIDTH(VW), .DEPTH(MAX_CELLS)) u_bwd (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr0(raddr0), .raddr1(raddr1), .rdata0(b_rd0), .rdata1(b_rd1)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      llws_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = s_tuser ? llws_pkg::ST_FILL : llws_pkg::ST_HEAD_RD;
        end
      end
      llws_pkg::ST_FILL: begin
        if (idx == LAST) begin
          state_next = report ? llws_pkg::ST_FIN_RD : llws_pkg::ST_IDLE;
        end
      end
      llws_pkg::ST_HEAD_RD: state_next = llws_pkg::ST_HEAD_WR;
      llws_pkg::ST_HEAD_WR: begin
        state_next = (n == '0) ? llws_pkg::ST_FIN_RD : llws_pkg::ST_CELL_RD;
      end
      llws_pkg::ST_CELL_RD:  state_next = llws_pkg::ST_CELL_MUL;
      llws_pkg::ST_CELL_MUL: state_next = llws_pkg::ST_CELL_WR;
      llws_pkg::ST_CELL_WR: begin
        if (self_cell) begin
          state_next = llws_pkg::ST_SELF_MUL;
        end else begin
          state_next = (idx == n) ? llws_pkg::ST_FIN_RD : llws_pkg::ST_CELL_RD;
        end
      end
      llws_pkg::ST_SELF_MUL: state_next = llws_pkg::ST_SELF_WR;
      llws_pkg::ST_SELF_WR: begin
        state_next = (idx == n) ? llws_pkg::ST_FIN_RD : llws_pkg::ST_CELL_RD;
      end
      llws_pkg::ST_FIN_RD: state_next = llws_pkg::ST_FIN_OUT;
      llws_pkg::ST_FIN_OUT: begin
        if (out_free) begin
          state_next = llws_pkg::ST_IDLE;
        end
      end
      default: state_next = llws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llws_pkg::ST_FILL;
      idx <= '0;
      ub <= '0;
      report <= 1'b0;
      m_tvalid <= 1'b0;
      steps <= 8'd1;
      atten <= 17'd65536;
      refl <= 17'd0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          llws_pkg::REG_STEPS: steps <= cfg_data[7:0];
          llws_pkg::REG_ATTEN: atten <= cfg_data;
          llws_pkg::REG_REFL:  refl <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        ub <= $signed(s_tdata[23:0]);
        ue <= $signed(s_tdata[47:24]);
        report <= 1'b1;
        idx <= '0;
      end
      if (state == llws_pkg::ST_FILL && idx != LAST) begin
        idx <= idx + 1'b1;
      end
      if (state == llws_pkg::ST_HEAD_WR) begin
        fold <= $signed(f_rd0);
        bold <= $signed(b_rd0);
        idx <= AW'(1);
      end
      if (state == llws_pkg::ST_CELL_MUL) begin
        prod_fa <= llws_pkg::qmul(fold, atten);
        prod_fr <= llws_pkg::qmul($signed(b_rd1), refl);
        prod_ba <= llws_pkg::qmul(bold, atten);
        prod_br <= llws_pkg::qmul($signed(f_rd1), refl);
        fold <= $signed(f_rd0);
        bold <= $signed(b_rd0);
      end
      if (state == llws_pkg::ST_CELL_WR) begin
        fself <= f_new;
        if (!self_cell && idx != n) begin
          idx <= idx + 1'b1;
        end
      end
      if (state == llws_pkg::ST_SELF_MUL) begin
        prod_br <= llws_pkg::qmul(fself, refl);
      end
      if (state == llws_pkg::ST_SELF_WR && idx != n) begin
        idx <= idx + 1'b1;
      end
      if (state == llws_pkg::ST_FIN_OUT && out_free) begin
        m_tvalid <= 1'b1;
        v_begin <= $signed(b_rd0);
        v_end <= $signed(f_rd0);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/llws_check.sv =====
module llws_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // held result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result too early");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("not clearing after reset");

endmodule

bind lossy_line_wave_step llws_check u_llws_check (.*);

// ===== dv/tb_lossy_line_wave_step.sv =====
`timescale 1ns / 1ps

module tb_lossy_line_wave_step;

  localparam int NCELL = llws_pkg::MAX_CELLS;
  localparam int CYCLE_LIMIT = 4000000;

  typedef enum logic {CMD_STEP = 1'b0, CMD_FILL = 1'b1} cmd_t;

  typedef struct {
    cmd_t cmd;
    logic signed [23:0] ub;
    logic signed [23:0] ue;
    logic has_exp;
    logic signed [23:0] vb;
    logic signed [23:0] ve;
  } row_t;

  typedef struct {
    logic signed [23:0] vb;
    logic signed [23:0] ve;
  } volt_pair_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;   // u_begin, u_end
  logic s_tuser;          // cmd
  logic m_tvalid;
  logic m_tready;
  logic [47:0] m_tdata;   // v_begin, v_end
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [16:0] cfg_data;

  lossy_line_wave_step i_dut (.*);

  // line model state
  logic signed [23:0] fwd_line [NCELL];
  logic signed [23:0] bwd_line [NCELL];
  int unsigned line_len;
  int unsigned atten_q;
  int unsigned refl_q;

  volt_pair_t end_volts_q[$];
  int errors;
  int cycles;
  int sent;
  bit idle_on;
  bit long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint scale_round(longint v, longint f);
    longint p;
    p = v * f + 32768;
    return p >>> 16;
  endfunction

  function automatic logic signed [23:0] clip24(longint x);
    if (x > 8388607) return 24'sh7fffff;
    if (x < -8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic volt_pair_t advance_line(cmd_t c, logic signed [23:0] ub,
                                              logic signed [23:0] ue);
    int unsigned n;
    longint f_prev;
    longint b_prev;
    longint hold;
    volt_pair_t r;
    n = (line_len > NCELL - 1) ? NCELL - 1 : line_len;
    if (c == CMD_FILL) begin
      for (int i = 0; i < NCELL; i++) begin
        fwd_line[i] = ub;
        bwd_line[i] = ub;
      end
    end else begin
      f_prev = fwd_line[0];
      b_prev = bwd_line[0];
      fwd_line[0] = clip24(longint'(ub) - longint'(bwd_line[n]));
      bwd_line[0] = clip24(longint'(ue) - longint'(fwd_line[n]));
      for (int unsigned i = 1; i <= n; i++) begin
        hold = fwd_line[i];
        fwd_line[i] = clip24(scale_round(f_prev, atten_q) +
                             scale_round(bwd_line[n - i], refl_q));
        f_prev = hold;
        hold = bwd_line[i];
        bwd_line[i] = clip24(scale_round(b_prev, atten_q) +
                             scale_round(fwd_line[n - i], refl_q));
        b_prev = hold;
      end
    end
    r.vb = bwd_line[n];
    r.ve = fwd_line[n];
    return r;
  endfunction

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  // output side: compare and apply back pressure
  always @(posedge clk) begin
    volt_pair_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (end_volts_q.size() == 0) begin
        report("unexpected result", m_tdata[23:0], 24'd0);
      end else begin
        e = end_volts_q.pop_front();
        if (m_tdata[23:0] !== e.vb) report("v_begin", m_tdata[23:0], e.vb);
        if (m_tdata[47:24] !== e.ve) report("v_end", m_tdata[47:24], e.ve);
      end
    end
  end

  initial begin
    int gap;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 12);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(llws_pkg::reg_index_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      llws_pkg::REG_STEPS: line_len = val & 8'hff;
      llws_pkg::REG_ATTEN: atten_q = val & 17'h1ffff;
      llws_pkg::REG_REFL:  refl_q = val & 17'h1ffff;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (end_volts_q.size() != 0) @(posedge clk);
    repeat (3 * NCELL + 20) @(posedge clk);
  endtask

  task automatic send_request(cmd_t c, logic signed [23:0] ub, logic signed [23:0] ue,
                              logic has_exp, volt_pair_t want);
    volt_pair_t p;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {ue, ub};
    do @(posedge clk); while (!s_tready);
    p = advance_line(c, ub, ue);
    if (has_exp && p.vb !== want.vb) report("directed v_begin", p.vb, want.vb);
    if (has_exp && p.ve !== want.ve) report("directed v_end", p.ve, want.ve);
    end_volts_q.insert(end_volts_q.size(), p);
    sent++;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic signed [23:0] a;
    logic signed [23:0] b;
    volt_pair_t none;
    none.vb = 0;
    none.ve = 0;
    for (int k = 0; k < count; k++) begin
      a = 24'($urandom);
      b = 24'($urandom);
      if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      if ($urandom_range(0, 3) == 0) begin
        a = a >>> 12;
        b = b >>> 12;
      end
      send_request($urandom_range(0, 19) == 0 ? CMD_FILL : CMD_STEP, a, b, 1'b0, none);
    end
  endtask

  row_t rows[$];

  task automatic add_row(row_t r);
    rows.insert(rows.size(), r);
  endtask

  initial begin
    volt_pair_t w;
    int unsigned steps_set [8];
    int unsigned fac_set [8];
    steps_set = '{0, 1, 2, 3, 255, 7, 16, 4};
    fac_set = '{65536, 0, 131071, 32768, 65535, 70000, 1, 50000};
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= llws_pkg::REG_STEPS;
    cfg_data <= '0;
    errors = 0;
    cycles = 0;
    sent = 0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    for (int i = 0; i < NCELL; i++) begin
      fwd_line[i] = 0;
      bwd_line[i] = 0;
    end
    line_len = 1;
    atten_q = 65536;
    refl_q = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows at reset settings: n = 1, atten one, refl zero
    add_row('{CMD_STEP, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0});
    add_row('{CMD_STEP, 24'sd100, 24'sd50, 1'b1, 24'sd0, 24'sd0});
    add_row('{CMD_STEP, 24'sd0, 24'sd0, 1'b1, 24'sd50, 24'sd100});
    add_row('{CMD_FILL, 24'sh7fffff, 24'sd0, 1'b1, 24'sh7fffff, 24'sh7fffff});
    add_row('{CMD_STEP, 24'sh800000, 24'sh800000, 1'b0, 24'sd0, 24'sd0});
    add_row('{CMD_STEP, 24'sh7fffff, 24'sh7fffff, 1'b0, 24'sd0, 24'sd0});
    add_row('{CMD_FILL, 24'sh800000, 24'sh7fffff, 1'b1, 24'sh800000, 24'sh800000});
    add_row('{CMD_STEP, 24'sh7fffff, 24'sh800000, 1'b0, 24'sd0, 24'sd0});
    add_row('{CMD_FILL, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0});
    add_row('{CMD_STEP, 24'sh555555, 24'shaaaaaa, 1'b0, 24'sd0, 24'sd0});
    foreach (rows[k]) begin
      w.vb = rows[k].vb;
      w.ve = rows[k].ve;
      send_request(rows[k].cmd, rows[k].ub, rows[k].ue, rows[k].has_exp, w);
    end
    drain();

    // sweep through line lengths and factors, including zero steps and full length
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(llws_pkg::REG_STEPS, steps_set[ph]);
      write_reg(llws_pkg::REG_ATTEN, fac_set[ph]);
      write_reg(llws_pkg::REG_REFL, fac_set[(ph + 3) % 8]);
      if (ph == 2) long_hold = 1'b1;
      if (ph == 7) idle_on = 1'b0;
      random_phase(steps_set[ph] == 255 ? 60 : 230);
      drain();
    end
    // raw 17-bit extremes with the self-mirror case (even n)
    write_reg(llws_pkg::REG_STEPS, 8'd6);
    write_reg(llws_pkg::REG_ATTEN, 17'h1ffff);
    write_reg(llws_pkg::REG_REFL, 17'h1ffff);
    random_phase(50);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/llws_pkg.sv
design/llws_ram.sv
design/lossy_line_wave_step.sv
design/llws_check.sv
dv/tb_lossy_line_wave_step.sv
